[sv/utf8sp_pkg.sv]
package utf8sp_pkg;

  // Code points decoded here never exceed 21 bits.
  localparam int CP_W = 21;
  // One item yields at most three code points (an unfinished sequence replayed at end of text).
  localparam int NSLOT = 3;
  localparam int NCNT = 6;
  localparam int OUT_W = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  // Widest per-item increment is NSLOT, which fits in two bits.
  localparam int INC_W = 2;

  localparam int CNT_CHAR  = 0;
  localparam int CNT_WORD  = 1;
  localparam int CNT_CJK   = 2;
  localparam int CNT_ARHE  = 3;
  localparam int CNT_CYR   = 4;
  localparam int CNT_OTHER = 5;

  typedef logic [CP_W-1:0] cp_t;

  typedef struct packed {
    logic space;
    logic cjk;
    logic arhe;
    logic cyr;
    logic other;
  } class_t;

  typedef struct packed {
    logic go;
    logic clear;
    logic eot;
  } step_ctl_t;

endpackage

[sv/utf8sp_decoder.sv]
module utf8sp_decoder
  import utf8sp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  step_ctl_t        ctl,
  input  logic [7:0]       data_byte,
  output cp_t              cp [NSLOT],
  output logic [NSLOT-1:0] cp_valid
);

  logic [7:0] pend_r [3];
  logic [1:0] fill_r, fill_nxt;
  logic [2:0] seq_r, seq_nxt;

  logic [7:0] buf0, buf1, buf2, buf3;
  logic [2:0] need, n;
  logic       complete, fire;
  cp_t        full_cp;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    if (c[7] == 1'b0) begin
      len = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  always_comb begin
    buf0 = (fill_r > 2'd0) ? pend_r[0] : data_byte;
    buf1 = (fill_r > 2'd1) ? pend_r[1] : data_byte;
    buf2 = (fill_r > 2'd2) ? pend_r[2] : data_byte;
    buf3 = data_byte;
    n    = {1'b0, fill_r} + 3'd1;
    need = (fill_r == 2'd0) ? lead_len(data_byte) : seq_r;
    complete = (n >= need);
    fire     = complete || ctl.eot;

    case (need)
      3'd2:    full_cp = CP_W'({buf0[4:0], buf1[5:0]});
      3'd3:    full_cp = CP_W'({buf0[3:0], buf1[5:0], buf2[5:0]});
      3'd4:    full_cp = CP_W'({buf0[2:0], buf1[5:0], buf2[5:0], buf3[5:0]});
      default: full_cp = CP_W'(buf0);
    endcase

    cp[1] = CP_W'(buf1);
    cp[2] = CP_W'(buf2);
    if (complete) begin
      cp[0]    = full_cp;
      cp_valid = 3'b001;
    end else begin
      // Unfinished sequence at end of text: the lead stands alone and the
      // rest is decoded afresh; only a two-byte lead can still complete.
      cp[0] = CP_W'(buf0);
      case (n)
        3'd2: cp_valid = 3'b011;
        3'd3: begin
          if (lead_len(buf1) == 3'd2) begin
            cp[1]    = CP_W'({buf1[4:0], buf2[5:0]});
            cp_valid = 3'b011;
          end else begin
            cp_valid = 3'b111;
          end
        end
        default: cp_valid = 3'b001;
      endcase
      if (!ctl.eot) begin
        cp_valid = 3'b000;
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    seq_nxt  = seq_r;
    if (ctl.go) begin
      if (ctl.clear || fire) begin
        fill_nxt = 2'd0;
        seq_nxt  = 3'd0;
      end else begin
        fill_nxt = n[1:0];
        seq_nxt  = need;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      seq_r  <= 3'd0;
    end else begin
      fill_r <= fill_nxt;
      seq_r  <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go && !ctl.clear && !fire) begin
      case (fill_r)
        2'd0:    pend_r[0] <= data_byte;
        2'd1:    pend_r[1] <= data_byte;
        2'd2:    pend_r[2] <= data_byte;
        default: pend_r[2] <= data_byte;
      endcase
    end
  end

endmodule

[sv/utf8sp_classify.sv]
module utf8sp_classify
  import utf8sp_pkg::*;
(
  input  cp_t    cp,
  output class_t cls
);

  logic cjk, arhe, cyr, other;

  always_comb begin
    cjk  = (cp >= 21'h04E00 && cp <= 21'h09FFF) || (cp >= 21'h03040 && cp <= 21'h030FF) ||
           (cp >= 21'h0AC00 && cp <= 21'h0D7AF) || (cp >= 21'h03400 && cp <= 21'h04DBF) ||
           (cp >= 21'h20000 && cp <= 21'h2A6DF);
    arhe = (cp >= 21'h00600 && cp <= 21'h006FF) || (cp >= 21'h00590 && cp <= 21'h005FF) ||
           (cp >= 21'h0FB1D && cp <= 21'h0FDFF);
    cyr  = (cp >= 21'h00400 && cp <= 21'h0052F);
    other = (cp >= 21'h00080 && cp <= 21'h0024F) || (cp >= 21'h00900 && cp <= 21'h0097F) ||
            (cp >= 21'h00E00 && cp <= 21'h00E7F);

    cls.space = (cp == 21'h20) || (cp == 21'h09) || (cp == 21'h0A) || (cp == 21'h0D);
    cls.cjk   = cjk;
    cls.arhe  = !cjk && arhe;
    cls.cyr   = !cjk && !arhe && cyr;
    cls.other = !cjk && !arhe && !cyr && other;
  end

endmodule

[sv/utf8sp_tally.sv]
module utf8sp_tally
  import utf8sp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  step_ctl_t              ctl,
  input  logic [NSLOT-1:0]       cp_valid,
  input  class_t [NSLOT-1:0]     cls,
  output logic [COUNT_WIDTH-1:0] count [NCNT]
);

  logic [COUNT_WIDTH-1:0] cnt_r [NCNT];
  logic [COUNT_WIDTH-1:0] cnt_nxt [NCNT];
  logic [INC_W-1:0]       inc [NCNT];
  logic [COUNT_WIDTH:0]   sum [NCNT];
  logic                   iw_r, iw_nxt;
  logic                   iw;

  // Word starts depend on the running inside-word flag, so walk the slots in order.
  always_comb begin
    for (int k = 0; k < NCNT; k++) begin
      inc[k] = '0;
    end
    iw = iw_r;
    for (int s = 0; s < NSLOT; s++) begin
      if (cp_valid[s]) begin
        inc[CNT_CHAR]  = inc[CNT_CHAR] + INC_W'(1);
        inc[CNT_CJK]   = inc[CNT_CJK] + INC_W'(cls[s].cjk);
        inc[CNT_ARHE]  = inc[CNT_ARHE] + INC_W'(cls[s].arhe);
        inc[CNT_CYR]   = inc[CNT_CYR] + INC_W'(cls[s].cyr);
        inc[CNT_OTHER] = inc[CNT_OTHER] + INC_W'(cls[s].other);
        if (!cls[s].space && !iw) begin
          inc[CNT_WORD] = inc[CNT_WORD] + INC_W'(1);
          iw = 1'b1;
        end else if (cls[s].space) begin
          iw = 1'b0;
        end
      end
    end
    if (ctl.eot) begin
      iw = 1'b0;
    end

    iw_nxt = iw_r;
    if (ctl.go) begin
      iw_nxt = ctl.clear ? 1'b0 : iw;
    end

    for (int k = 0; k < NCNT; k++) begin
      // Increments are small, so one carry out of the top bit means saturate.
      sum[k] = {1'b0, cnt_r[k]} + (COUNT_WIDTH + 1)'(inc[k]);
      cnt_nxt[k] = cnt_r[k];
      if (ctl.go) begin
        if (ctl.clear) begin
          cnt_nxt[k] = '0;
        end else if (sum[k][COUNT_WIDTH]) begin
          cnt_nxt[k] = '1;
        end else begin
          cnt_nxt[k] = sum[k][COUNT_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= 1'b0;
      for (int k = 0; k < NCNT; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      iw_r <= iw_nxt;
      for (int k = 0; k < NCNT; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  assign count = cnt_r;

endmodule

[sv/utf8_script_profiler_top.sv]
// Channel   Handshake              Payload
// in_       in_valid / in_stall    in_command, in_data_byte, in_end_of_text
// out_      out_valid / out_stall  six 32-bit counter values after the item
//
// One item per cycle sustained while out_stall is low; each result appears on
// the output after its item passes the input register, then decode and counter update.
// The counter registers serve as the result register: they only advance when
// the output slot is free or is being taken in the same cycle.
// Reset is synchronous and active low and clears counters and decode state.
// An output stall holds the result and backs up into in_stall one item later.
module utf8_script_profiler_top
  import utf8sp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_command,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_text,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_char_count,
  output logic [OUT_W-1:0] out_word_count,
  output logic [OUT_W-1:0] out_cjk_count,
  output logic [OUT_W-1:0] out_arabic_hebrew_count,
  output logic [OUT_W-1:0] out_cyrillic_count,
  output logic [OUT_W-1:0] out_other_multibyte_count
);

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_command_r;
  logic [7:0] s1_byte_r;
  logic       s1_eot_r;
  logic       out_valid_r, out_valid_nxt;
  logic       go;

  step_ctl_t              ctl;
  cp_t                    cp [NSLOT];
  logic [NSLOT-1:0]       cp_valid;
  class_t [NSLOT-1:0]     cls;
  logic [COUNT_WIDTH-1:0] count [NCNT];
  logic [COUNT_WIDTH+OUT_W-1:0] count_ext [NCNT];

  assign go       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !go;

  always_comb begin
    s1_valid_nxt = in_stall ? s1_valid_r : in_valid;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_command_r <= in_command;
      s1_byte_r    <= in_data_byte;
      s1_eot_r     <= in_end_of_text;
    end
  end

  assign ctl.go    = go;
  assign ctl.clear = s1_command_r;
  assign ctl.eot   = s1_eot_r;

  utf8sp_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (s1_byte_r),
    .cp        (cp),
    .cp_valid  (cp_valid)
  );

  for (genvar s = 0; s < NSLOT; s++) begin : g_cls
    utf8sp_classify u_classify (
      .cp  (cp[s]),
      .cls (cls[s])
    );
  end

  utf8sp_tally #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tally (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .cp_valid (cp_valid),
    .cls      (cls),
    .count    (count)
  );

  // Zero-extend so narrow counters also fill the 32-bit result fields.
  always_comb begin
    for (int k = 0; k < NCNT; k++) begin
      count_ext[k] = {{OUT_W{1'b0}}, count[k]};
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_char_count            = count_ext[CNT_CHAR][OUT_W-1:0];
  assign out_word_count            = count_ext[CNT_WORD][OUT_W-1:0];
  assign out_cjk_count             = count_ext[CNT_CJK][OUT_W-1:0];
  assign out_arabic_hebrew_count   = count_ext[CNT_ARHE][OUT_W-1:0];
  assign out_cyrillic_count        = count_ext[CNT_CYR][OUT_W-1:0];
  assign out_other_multibyte_count = count_ext[CNT_OTHER][OUT_W-1:0];

endmodule
